// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the mask channel scaler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies another condition in the same cycle.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// Checks that a condition implies another condition in the next cycle.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/mcns_pkg.sv =====
// Package with the types, constants and helper functions of the mask channel scaler.
package mcns_pkg;

  // Image size limits and the widths that follow from them.
  localparam int MAX_DIM    = 256;
  localparam int MAX_PIXELS = 65536;
  localparam int DIM_W      = $clog2(MAX_DIM) + 1;
  localparam int COORD_W    = $clog2(MAX_DIM);
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int COUNT_W    = ADDR_W + 1;
  localparam int MUL_W      = 2 * DIM_W;
  localparam int DIVD_W     = 2 * COORD_W;
  localparam int DIV_STEPS  = COORD_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int CHAN_W     = 8;
  localparam int WORD_W     = 2 * CHAN_W;

  // Divide by three through a scaled reciprocal.
  localparam int MEAN_RECIP = 683;
  localparam int MEAN_SHIFT = 11;
  localparam int SUM_W      = CHAN_W + 2;
  localparam int MEAN_P_W   = SUM_W + 10;

  // Alpha range reset values.
  localparam logic [CHAN_W-1:0] ALPHA_FULL = '1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 2'd3;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] mask_byte;
    logic              last;
  } out_item_t;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCOUNT,
    ST_STORE,
    ST_TCOUNT,
    ST_SELECT,
    ST_MUL_Y,
    ST_DIV_Y,
    ST_MUL_X,
    ST_DIV_X,
    ST_INDEX,
    ST_READ,
    ST_EMIT
  } state_t;

  // Zero acts as one and values beyond the limit act as the limit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Truncated mean of three channels.
  function automatic logic [CHAN_W-1:0] mean3(input logic [CHAN_W-1:0] r,
                                              input logic [CHAN_W-1:0] g,
                                              input logic [CHAN_W-1:0] b);
    logic [SUM_W-1:0]    sum;
    logic [MEAN_P_W-1:0] prod;
    sum  = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
    prod = MEAN_P_W'(sum) * MEAN_P_W'(MEAN_RECIP);
    return prod[MEAN_SHIFT +: CHAN_W];
  endfunction

endpackage

// ===== rtl/mcns_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mcns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== rtl/mcns_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module mcns_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mcns_pkg::DIVD_W-1:0]    dividend,
  input  logic [mcns_pkg::DIM_W-1:0]     divisor,
  output mcns_pkg::div_status_t          status,
  output logic [mcns_pkg::COORD_W-1:0]   quotient
);

  logic [mcns_pkg::DIM_W-1:0]   rem_r;
  logic [mcns_pkg::DIM_W-1:0]   rem_nxt;
  logic [mcns_pkg::COORD_W-1:0] num_r;
  logic [mcns_pkg::COORD_W-1:0] quo_r;
  logic [mcns_pkg::DIM_W-1:0]   den_r;
  logic [mcns_pkg::STEP_W-1:0]  step_r;
  logic                         busy_r;
  logic                         done_r;
  logic [mcns_pkg::DIM_W:0]     trial;
  logic                         q_bit;

  // One trial subtraction. The quotient is known to fit, so the
  // remainder stays below the divisor and one subtraction suffices.
  always_comb begin
    trial = {rem_r, num_r[mcns_pkg::COORD_W-1]};
    q_bit = (trial >= {1'b0, den_r});
    if (q_bit) begin
      rem_nxt = mcns_pkg::DIM_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[mcns_pkg::DIM_W-1:0];
    end
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == mcns_pkg::STEP_W'(mcns_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder, dividend bits and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[mcns_pkg::DIVD_W-1 -: mcns_pkg::COORD_W]};
      num_r <= dividend[mcns_pkg::COORD_W-1:0];
      den_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[mcns_pkg::COORD_W-2:0], 1'b0};
      quo_r <= {quo_r[mcns_pkg::COORD_W-2:0], q_bit};
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

// ===== rtl/mask_channel_nearest_scaler.sv =====
// Top level of the mask channel scaler: sequencer, shared multiplier, shared divider and pixel store.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  input   | start / busy         | in_item  (kind, blue, green, red, alpha)
//  result  | out_valid strobe     | out_item (mask_byte, last)
//  config  | cfg_we               | cfg_index, cfg_data
//
// A load item keeps the block busy through the SCOUNT and STORE states after its transfer.
// An emit item goes through SCOUNT, TCOUNT, SELECT, READ and EMIT when source and target pixel counts
// match, and when scaled also through multiplies, up to two 8-step divisions on the shared divider and INDEX.
// The result strobe comes in the cycle after the last busy cycle.
// Reset is synchronous; the pixel store is not cleared and needs no sweep.
// The receiver cannot stall, so results are never held back.
`include "assert_macros.svh"

module mask_channel_nearest_scaler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  mcns_pkg::in_item_t                in_item,
  output logic                              out_valid,
  output mcns_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [mcns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcns_pkg::DIM_W-1:0]        cfg_data
);

  // Configuration registers.
  logic [mcns_pkg::DIM_W-1:0] cfg_sw_r;
  logic [mcns_pkg::DIM_W-1:0] cfg_sh_r;
  logic [mcns_pkg::DIM_W-1:0] cfg_tw_r;
  logic [mcns_pkg::DIM_W-1:0] cfg_th_r;
  logic [mcns_pkg::DIM_W-1:0] sw;
  logic [mcns_pkg::DIM_W-1:0] sh;
  logic [mcns_pkg::DIM_W-1:0] tw;
  logic [mcns_pkg::DIM_W-1:0] th;

  // Sequencer and working registers.
  mcns_pkg::state_t               state_r;
  mcns_pkg::state_t               state_nxt;
  mcns_pkg::in_item_t             item_r;
  logic [mcns_pkg::COUNT_W-1:0]   scount_r;
  logic [mcns_pkg::COUNT_W-1:0]   tcount_r;
  logic [mcns_pkg::COUNT_W-1:0]   load_count_r;
  logic [mcns_pkg::CHAN_W-1:0]    alpha_low_r;
  logic [mcns_pkg::CHAN_W-1:0]    alpha_high_r;
  logic [mcns_pkg::COORD_W-1:0]   out_col_r;
  logic [mcns_pkg::ADDR_W-1:0]    out_row_r;
  logic [mcns_pkg::ADDR_W-1:0]    out_linear_r;
  logic [mcns_pkg::COORD_W-1:0]   sy_r;
  logic [mcns_pkg::COORD_W-1:0]   sx_r;
  logic [mcns_pkg::ADDR_W-1:0]    idx_r;
  logic                           out_valid_r;
  mcns_pkg::out_item_t            out_item_r;

  // Shared multiplier.
  logic [mcns_pkg::DIM_W-1:0]     mul_a;
  logic [mcns_pkg::DIM_W-1:0]     mul_b;
  logic [mcns_pkg::MUL_W-1:0]     mul_p;

  // Shared divider.
  logic                           div_start;
  logic [mcns_pkg::DIM_W-1:0]     div_den;
  mcns_pkg::div_status_t          div_status;
  logic [mcns_pkg::COORD_W-1:0]   div_q;

  // Pixel store.
  logic                           ram_we;
  logic                           ram_re;
  logic [mcns_pkg::WORD_W-1:0]    ram_wdata;
  logic [mcns_pkg::WORD_W-1:0]    ram_rdata;

  // Misc decode.
  logic                           accept;
  logic                           counts_equal;
  logic                           row_clamp;
  logic                           col_clamp;
  logic                           load_ok;
  logic                           prefer_alpha;
  logic                           is_last;
  logic [mcns_pkg::DIM_W-1:0]     col_inc;
  logic [mcns_pkg::ADDR_W-1:0]    lin_idx;
  logic                           div_wait;

  assign accept = start && !busy;
  assign busy   = (state_r != mcns_pkg::ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sw_r <= mcns_pkg::DIM_W'(1);
      cfg_sh_r <= mcns_pkg::DIM_W'(1);
      cfg_tw_r <= mcns_pkg::DIM_W'(1);
      cfg_th_r <= mcns_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcns_pkg::CFG_SOURCE_WIDTH:  cfg_sw_r <= cfg_data;
        mcns_pkg::CFG_SOURCE_HEIGHT: cfg_sh_r <= cfg_data;
        mcns_pkg::CFG_TARGET_WIDTH:  cfg_tw_r <= cfg_data;
        mcns_pkg::CFG_TARGET_HEIGHT: cfg_th_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes after clamping.
  assign sw = mcns_pkg::eff_dim(cfg_sw_r);
  assign sh = mcns_pkg::eff_dim(cfg_sh_r);
  assign tw = mcns_pkg::eff_dim(cfg_tw_r);
  assign th = mcns_pkg::eff_dim(cfg_th_r);

  // Comparisons that steer the sequencer.
  assign counts_equal = (scount_r == tcount_r);
  assign row_clamp    = (out_row_r >= mcns_pkg::ADDR_W'(th));
  assign col_clamp    = ({1'b0, out_col_r} >= tw);
  assign load_ok      = (load_count_r < scount_r);
  assign lin_idx      = ({1'b0, out_linear_r} >= scount_r) ?
                        mcns_pkg::ADDR_W'(scount_r - 1'b1) : out_linear_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_r)
      mcns_pkg::ST_SCOUNT: begin
        mul_a = sw;
        mul_b = sh;
      end
      mcns_pkg::ST_TCOUNT: begin
        mul_a = tw;
        mul_b = th;
      end
      mcns_pkg::ST_MUL_Y: begin
        mul_a = {1'b0, out_row_r[mcns_pkg::COORD_W-1:0]};
        mul_b = sh;
      end
      mcns_pkg::ST_MUL_X: begin
        mul_a = {1'b0, out_col_r};
        mul_b = sw;
      end
      mcns_pkg::ST_INDEX: begin
        mul_a = {1'b0, sy_r};
        mul_b = sw;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Next state and divider launch.
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_den   = tw;
    unique case (state_r)
      mcns_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = mcns_pkg::ST_SCOUNT;
        end
      end
      mcns_pkg::ST_SCOUNT: begin
        if (item_r.kind == mcns_pkg::KIND_EMIT) begin
          state_nxt = mcns_pkg::ST_TCOUNT;
        end else begin
          state_nxt = mcns_pkg::ST_STORE;
        end
      end
      mcns_pkg::ST_STORE: begin
        state_nxt = mcns_pkg::ST_IDLE;
      end
      mcns_pkg::ST_TCOUNT: begin
        state_nxt = mcns_pkg::ST_SELECT;
      end
      mcns_pkg::ST_SELECT: begin
        if (counts_equal) begin
          state_nxt = mcns_pkg::ST_READ;
        end else begin
          state_nxt = mcns_pkg::ST_MUL_Y;
        end
      end
      mcns_pkg::ST_MUL_Y: begin
        div_den = th;
        if (row_clamp) begin
          state_nxt = mcns_pkg::ST_MUL_X;
        end else begin
          div_start = 1'b1;
          state_nxt = mcns_pkg::ST_DIV_Y;
        end
      end
      mcns_pkg::ST_DIV_Y: begin
        if (div_status.done) begin
          state_nxt = mcns_pkg::ST_MUL_X;
        end
      end
      mcns_pkg::ST_MUL_X: begin
        if (col_clamp) begin
          state_nxt = mcns_pkg::ST_INDEX;
        end else begin
          div_start = 1'b1;
          state_nxt = mcns_pkg::ST_DIV_X;
        end
      end
      mcns_pkg::ST_DIV_X: begin
        if (div_status.done) begin
          state_nxt = mcns_pkg::ST_INDEX;
        end
      end
      mcns_pkg::ST_INDEX: begin
        state_nxt = mcns_pkg::ST_READ;
      end
      mcns_pkg::ST_READ: begin
        state_nxt = mcns_pkg::ST_EMIT;
      end
      mcns_pkg::ST_EMIT: begin
        state_nxt = mcns_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mcns_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcns_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the item on its transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  // Pixel counts, coordinates and store index.
  always_ff @(posedge clk) begin
    if (state_r == mcns_pkg::ST_SCOUNT) begin
      scount_r <= mul_p[mcns_pkg::COUNT_W-1:0];
    end
    if (state_r == mcns_pkg::ST_TCOUNT) begin
      tcount_r <= mul_p[mcns_pkg::COUNT_W-1:0];
    end
    if (state_r == mcns_pkg::ST_MUL_Y && row_clamp) begin
      sy_r <= mcns_pkg::COORD_W'(sh - 1'b1);
    end else if (state_r == mcns_pkg::ST_DIV_Y && div_status.done) begin
      sy_r <= div_q;
    end
    if (state_r == mcns_pkg::ST_MUL_X && col_clamp) begin
      sx_r <= mcns_pkg::COORD_W'(sw - 1'b1);
    end else if (state_r == mcns_pkg::ST_DIV_X && div_status.done) begin
      sx_r <= div_q;
    end
    if (state_r == mcns_pkg::ST_SELECT) begin
      idx_r <= lin_idx;
    end else if (state_r == mcns_pkg::ST_INDEX) begin
      idx_r <= mul_p[mcns_pkg::ADDR_W-1:0] + mcns_pkg::ADDR_W'(sx_r);
    end
  end

  // Byte selection and last flag for the emitted result.
  assign prefer_alpha = (alpha_high_r > alpha_low_r) &&
                        ((alpha_low_r != mcns_pkg::ALPHA_FULL) ||
                         (alpha_high_r != mcns_pkg::ALPHA_FULL));
  assign is_last      = ({1'b0, out_linear_r} >= (tcount_r - 1'b1));
  assign col_inc      = {1'b0, out_col_r} + 1'b1;

  // Load count, alpha range and output raster counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      alpha_low_r  <= mcns_pkg::ALPHA_FULL;
      alpha_high_r <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      out_linear_r <= '0;
    end else if (state_r == mcns_pkg::ST_STORE && load_ok) begin
      load_count_r <= load_count_r + 1'b1;
      if (item_r.alpha < alpha_low_r) begin
        alpha_low_r <= item_r.alpha;
      end
      if (item_r.alpha > alpha_high_r) begin
        alpha_high_r <= item_r.alpha;
      end
    end else if (state_r == mcns_pkg::ST_EMIT) begin
      if (is_last) begin
        load_count_r <= '0;
        alpha_low_r  <= mcns_pkg::ALPHA_FULL;
        alpha_high_r <= '0;
        out_col_r    <= '0;
        out_row_r    <= '0;
        out_linear_r <= '0;
      end else begin
        out_linear_r <= out_linear_r + 1'b1;
        if (col_inc >= tw) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + 1'b1;
        end else begin
          out_col_r <= col_inc[mcns_pkg::COORD_W-1:0];
        end
      end
    end
  end

  // Result register: one strobe per emit item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == mcns_pkg::ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mcns_pkg::ST_EMIT) begin
      out_item_r.mask_byte <= prefer_alpha ? ram_rdata[mcns_pkg::WORD_W-1 -: mcns_pkg::CHAN_W]
                                           : ram_rdata[mcns_pkg::CHAN_W-1:0];
      out_item_r.last      <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Store port control.
  assign ram_we    = (state_r == mcns_pkg::ST_STORE) && load_ok;
  assign ram_re    = (state_r == mcns_pkg::ST_READ);
  assign ram_wdata = {item_r.alpha, mcns_pkg::mean3(item_r.red, item_r.green, item_r.blue)};

  mcns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_p[mcns_pkg::DIVD_W-1:0]),
    .divisor  (div_den),
    .status   (div_status),
    .quotient (div_q)
  );

  mcns_ram #(
    .WIDTH (mcns_pkg::WORD_W),
    .DEPTH (mcns_pkg::MAX_PIXELS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (load_count_r[mcns_pkg::ADDR_W-1:0]),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  // The sequencer waits on the divider in these two states.
  assign div_wait = (state_r == mcns_pkg::ST_DIV_Y) || (state_r == mcns_pkg::ST_DIV_X);

  // A result strobe only follows the emit step.
  `ASSERT_SAME_CYCLE(a_out_after_emit, clk, rst_n, out_valid, $past(state_r == mcns_pkg::ST_EMIT))

  // The divider finishes only while the sequencer waits on it.
  `ASSERT_SAME_CYCLE(a_div_done_waited, clk, rst_n, div_status.done, div_wait)

  // The store read stays inside the source image.
  `ASSERT_SAME_CYCLE(a_read_in_range, clk, rst_n, ram_re, ({1'b0, idx_r} < scount_r))

  // Once a pixel is stored, the alpha range is ordered.
  `ASSERT_SAME_CYCLE(a_alpha_ordered, clk, rst_n, load_count_r != '0, alpha_low_r <= alpha_high_r)

endmodule
